[rtl/core/mavg_rpm_pkg.sv]
// Package for the moving-average speed setpoint filter.
// Holds shared constants, operation codes and a width helper; no dependencies.
package mavg_rpm_pkg;

    localparam int DEF_WINDOW      = 10;
    localparam int DEF_SAMPLE_BITS = 12;
    localparam int RPM_BITS        = 15;
    localparam int RPM_Q8_BITS     = 23;
    localparam int FRAC_BITS       = 8;

    localparam logic [RPM_BITS-1:0] MAX_RPM_RESET = 15'd3000;

    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_PRIME  = 1'b1;

    function automatic int sum_bits(input int window, input int sample_bits);
        return $clog2(window * ((1 << sample_bits) - 1) + 1);
    endfunction

endpackage

[rtl/core/mavg_rpm_filter.sv]
// Sample window and running sum of the moving-average filter.
// Depends on mavg_rpm_pkg; feeds mavg_rpm_scale.
module mavg_rpm_filter #(
    parameter int WINDOW      = mavg_rpm_pkg::DEF_WINDOW,
    parameter int SAMPLE_BITS = mavg_rpm_pkg::DEF_SAMPLE_BITS,
    parameter int SUM_BITS    = mavg_rpm_pkg::sum_bits(WINDOW, SAMPLE_BITS)
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic                   i_op,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [SUM_BITS-1:0]    o_sum
);

    logic [SAMPLE_BITS-1:0] r_line [WINDOW];
    logic [SUM_BITS-1:0]    r_sum;
    logic                   r_valid;
    logic [SUM_BITS-1:0]    n_sum_prime;
    logic [SUM_BITS-1:0]    n_sum_update;
    logic                   accept;

    assign o_stall = r_valid && i_stall;
    assign accept  = i_valid && !o_stall;
    assign o_valid = r_valid;
    assign o_sum   = r_sum;

    always_comb begin
        n_sum_prime  = SUM_BITS'(i_sample) * SUM_BITS'(WINDOW);
        n_sum_update = r_sum - SUM_BITS'(r_line[WINDOW-1]) + SUM_BITS'(i_sample);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sum   <= '0;
            for (int k = 0; k < WINDOW; k++) begin
                r_line[k] <= '0;
            end
        end else if (accept) begin
            if (i_op == mavg_rpm_pkg::OP_PRIME) begin
                r_valid <= 1'b0;
                r_sum   <= n_sum_prime;
                for (int k = 0; k < WINDOW; k++) begin
                    r_line[k] <= i_sample;
                end
            end else begin
                r_valid   <= 1'b1;
                r_sum     <= n_sum_update;
                r_line[0] <= i_sample;
                for (int k = 1; k < WINDOW; k++) begin
                    r_line[k] <= r_line[k-1];
                end
            end
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

endmodule

[rtl/core/mavg_rpm_scale.sv]
// Scaling pipeline: multiplies the window sum by the full-scale speed and divides
// by window times converter full scale via a reciprocal. Depends on mavg_rpm_pkg.
module mavg_rpm_scale #(
    parameter int WINDOW      = mavg_rpm_pkg::DEF_WINDOW,
    parameter int SAMPLE_BITS = mavg_rpm_pkg::DEF_SAMPLE_BITS,
    parameter int SUM_BITS    = mavg_rpm_pkg::sum_bits(WINDOW, SAMPLE_BITS)
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [SUM_BITS-1:0]                 i_sum,
    input  logic [mavg_rpm_pkg::RPM_BITS-1:0]   i_max_rpm,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [mavg_rpm_pkg::RPM_Q8_BITS-1:0] o_rpm_q8
);

    localparam int QW   = mavg_rpm_pkg::RPM_Q8_BITS;
    localparam int FB   = mavg_rpm_pkg::FRAC_BITS;
    localparam int PW   = SUM_BITS + mavg_rpm_pkg::RPM_BITS;
    localparam int XW   = PW + FB;
    localparam int DIV  = WINDOW * ((1 << SAMPLE_BITS) - 1);
    localparam int DW   = $clog2(DIV + 1);
    localparam logic [63:0] RECIP = (64'd1 << XW) / 64'(DIV);
    localparam int MW   = $clog2(RECIP + 64'd1);
    localparam int PRW  = PW + MW;
    localparam int QDW  = QW + DW;

    localparam logic [MW-1:0] RECIP_M = MW'(RECIP);
    localparam logic [DW-1:0] DIV_M   = DW'(DIV);

    logic            r_v1, r_v2, r_v3, r_v4;
    logic [PW-1:0]   r_p1, r_p2, r_p3;
    logic [QW-1:0]   r_q2, r_q3, r_q4;
    logic [QDW-1:0]  r_qd3;
    logic            adv1, adv2, adv3, adv4;
    logic [PRW-1:0]  prod;
    logic [QW-1:0]   q_est;
    logic [XW-1:0]   x_full;
    logic [XW-1:0]   rem;
    logic [QW-1:0]   n_q4;

    assign adv4    = !r_v4 || !i_stall;
    assign adv3    = !r_v3 || adv4;
    assign adv2    = !r_v2 || adv3;
    assign adv1    = !r_v1 || adv2;
    assign o_stall = !adv1;
    assign o_valid = r_v4;
    assign o_rpm_q8 = r_q4;

    always_comb begin
        prod   = PRW'(r_p1) * PRW'(RECIP_M);
        q_est  = QW'(prod >> (XW - FB));
        x_full = {r_p3, {FB{1'b0}}};
        rem    = x_full - XW'(r_qd3);
        n_q4   = (rem >= XW'(DIV_M)) ? r_q3 + QW'(1) : r_q3;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (adv1) begin
                r_v1 <= i_valid;
            end
            if (adv2) begin
                r_v2 <= r_v1;
            end
            if (adv3) begin
                r_v3 <= r_v2;
            end
            if (adv4) begin
                r_v4 <= r_v3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_p1 <= PW'(i_sum) * PW'(i_max_rpm);
        end
        if (adv2) begin
            r_p2 <= r_p1;
            r_q2 <= q_est;
        end
        if (adv3) begin
            r_p3  <= r_p2;
            r_q3  <= r_q2;
            r_qd3 <= QDW'(r_q2) * QDW'(DIV_M);
        end
        if (adv4) begin
            r_q4 <= n_q4;
        end
    end

endmodule

[rtl/core/moving_average_rpm_setpoint_top.sv]
// Top level of the moving-average speed setpoint filter.
// Instantiates mavg_rpm_filter and mavg_rpm_scale; depends on mavg_rpm_pkg.
//
// The block accepts one sample transaction per clock while o_stall is low. A prime
// transaction loads the whole window and gives no result. An update transaction is
// loaded into the window register at the accepting edge and then passes through the
// four-stage scaling pipeline (product, reciprocal multiply, back-multiply, remainder
// correction) before its target speed is offered; a stalled output holds it there.
// The window register and the scaling pipeline together can hold up to five
// transactions in flight. The full-scale speed register should only be written
// while no transaction is in flight.
module moving_average_rpm_setpoint_top #(
    parameter int WINDOW      = mavg_rpm_pkg::DEF_WINDOW,
    parameter int SAMPLE_BITS = mavg_rpm_pkg::DEF_SAMPLE_BITS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic                                 i_op,
    input  logic [SAMPLE_BITS-1:0]               i_sample,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic [mavg_rpm_pkg::RPM_Q8_BITS-1:0] o_rpm_q8,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [mavg_rpm_pkg::RPM_BITS-1:0]    i_cfg_data
);

    localparam int SUM_BITS = mavg_rpm_pkg::sum_bits(WINDOW, SAMPLE_BITS);

    logic [mavg_rpm_pkg::RPM_BITS-1:0] r_max_rpm;
    logic                              sum_valid;
    logic                              sum_stall;
    logic [SUM_BITS-1:0]               sum;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_rpm <= mavg_rpm_pkg::MAX_RPM_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_max_rpm <= i_cfg_data;
        end
    end

    mavg_rpm_filter #(
        .WINDOW      (WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS),
        .SUM_BITS    (SUM_BITS)
    ) u_filter (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_op     (i_op),
        .i_sample (i_sample),
        .o_valid  (sum_valid),
        .i_stall  (sum_stall),
        .o_sum    (sum)
    );

    mavg_rpm_scale #(
        .WINDOW      (WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS),
        .SUM_BITS    (SUM_BITS)
    ) u_scale (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (sum_valid),
        .o_stall   (sum_stall),
        .i_sum     (sum),
        .i_max_rpm (r_max_rpm),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_rpm_q8  (o_rpm_q8)
    );

endmodule

[rtl/core/mavg_rpm_checker.sv]
// Port-level checks for the moving-average speed setpoint filter, bound to the
// top level. Depends on mavg_rpm_pkg and moving_average_rpm_setpoint_top.
module mavg_rpm_checker (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 o_stall,
    input logic                                 o_valid,
    input logic                                 i_stall,
    input logic [mavg_rpm_pkg::RPM_Q8_BITS-1:0] o_rpm_q8
);

    localparam logic [mavg_rpm_pkg::RPM_Q8_BITS-1:0] RPM_Q8_LIMIT =
        mavg_rpm_pkg::RPM_Q8_BITS'({mavg_rpm_pkg::RPM_BITS{1'b1}}) << mavg_rpm_pkg::FRAC_BITS;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_rpm_q8))
        else $error("Stalled result transaction changed or was dropped.");

    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_rpm_q8 <= RPM_Q8_LIMIT)
        else $error("Result speed exceeds the largest full-scale value.");

    a_empty_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("Input stalled while the result register is empty.");

    a_flow_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_stall |-> !o_stall)
        else $error("Input stalled while the output is not stalled.");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("Result transaction offered straight after reset.");

endmodule

bind moving_average_rpm_setpoint_top mavg_rpm_checker u_mavg_rpm_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .o_stall  (o_stall),
    .o_valid  (o_valid),
    .i_stall  (i_stall),
    .o_rpm_q8 (o_rpm_q8)
);

[dv/tb_top.sv]
// Self-checking testbench for the moving-average speed setpoint filter.
// It drives sample transactions against a predictor of the window and the scaling.
// Depends on mavg_rpm_pkg and moving_average_rpm_setpoint_top.
module tb_top;
    import mavg_rpm_pkg::*;

    localparam int WINDOW        = DEF_WINDOW;
    localparam int SAMPLE_BITS   = DEF_SAMPLE_BITS;
    localparam int SAMPLE_MAX    = (1 << SAMPLE_BITS) - 1;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 194;
    localparam int SETTLE_CYCLES = 10;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int NUM_ROWS      = 25;

    typedef enum logic [1:0] {
        ROW_ITEM,
        ROW_ITEM_KNOWN,
        ROW_CFG
    } row_kind_e;

    typedef struct packed {
        row_kind_e               kind;
        logic                    op;
        logic [SAMPLE_BITS-1:0]  smp;
        logic [RPM_BITS-1:0]     cfg;
        logic [RPM_Q8_BITS-1:0]  rpm;
    } stim_row_t;

    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   i_valid     = 1'b0;
    logic                   o_stall;
    logic                   i_op        = OP_UPDATE;
    logic [SAMPLE_BITS-1:0] i_sample    = '0;
    logic                   o_valid;
    logic                   i_stall     = 1'b0;
    logic [RPM_Q8_BITS-1:0] o_rpm_q8;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [RPM_BITS-1:0]    i_cfg_data  = '0;

    logic [SAMPLE_BITS-1:0] ring_q [WINDOW];
    logic [15:0]            ring_sum;
    logic [3:0]             ring_slot;
    logic [RPM_BITS-1:0]    max_rpm_q;

    logic [RPM_Q8_BITS-1:0] rpm_expect_q [$];
    int                     mismatch_count = 0;
    int                     cycle_count    = 0;
    int                     calm_items     = 0;

    stim_row_t directed_rows [NUM_ROWS] = '{
        '{ROW_ITEM_KNOWN, OP_UPDATE, 12'd0,    15'd0,     23'd0},
        '{ROW_ITEM_KNOWN, OP_UPDATE, 12'd4095, 15'd0,     23'd76800},
        '{ROW_ITEM,       OP_UPDATE, 12'd1,    15'd0,     23'd0},
        '{ROW_ITEM,       OP_UPDATE, 12'd2048, 15'd0,     23'd0},
        '{ROW_ITEM,       OP_PRIME,  12'd4095, 15'd0,     23'd0},
        '{ROW_ITEM_KNOWN, OP_UPDATE, 12'd4095, 15'd0,     23'd768000},
        '{ROW_ITEM,       OP_UPDATE, 12'd0,    15'd0,     23'd0},
        '{ROW_ITEM,       OP_PRIME,  12'd0,    15'd0,     23'd0},
        '{ROW_ITEM_KNOWN, OP_UPDATE, 12'd0,    15'd0,     23'd0},
        '{ROW_ITEM,       OP_PRIME,  12'd2730, 15'd0,     23'd0},
        '{ROW_ITEM,       OP_UPDATE, 12'd1365, 15'd0,     23'd0},
        '{ROW_ITEM,       OP_UPDATE, 12'd4094, 15'd0,     23'd0},
        '{ROW_CFG,        OP_UPDATE, 12'd0,    15'd32767, 23'd0},
        '{ROW_ITEM,       OP_PRIME,  12'd4095, 15'd0,     23'd0},
        '{ROW_ITEM_KNOWN, OP_UPDATE, 12'd4095, 15'd0,     23'd8388352},
        '{ROW_CFG,        OP_UPDATE, 12'd0,    15'd0,     23'd0},
        '{ROW_ITEM_KNOWN, OP_UPDATE, 12'd4095, 15'd0,     23'd0},
        '{ROW_CFG,        OP_UPDATE, 12'd0,    15'd1,     23'd0},
        '{ROW_ITEM,       OP_PRIME,  12'd4095, 15'd0,     23'd0},
        '{ROW_ITEM_KNOWN, OP_UPDATE, 12'd4095, 15'd0,     23'd256},
        '{ROW_ITEM,       OP_UPDATE, 12'd0,    15'd0,     23'd0},
        '{ROW_CFG,        OP_UPDATE, 12'd0,    15'd20000, 23'd0},
        '{ROW_ITEM,       OP_PRIME,  12'd4095, 15'd0,     23'd0},
        '{ROW_ITEM_KNOWN, OP_UPDATE, 12'd4095, 15'd0,     23'd5120000},
        '{ROW_ITEM,       OP_UPDATE, 12'd2047, 15'd0,     23'd0}
    };

    moving_average_rpm_setpoint_top #(
        .WINDOW      (WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_op        (i_op),
        .i_sample    (i_sample),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_rpm_q8    (o_rpm_q8),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    // Advances the filter state by one transaction; returns 1 when a speed is produced.
    function automatic bit advance_filter(input logic op, input logic [SAMPLE_BITS-1:0] smp,
                                          output logic [RPM_Q8_BITS-1:0] rpm);
        logic [63:0] num;
        int          k;
        rpm = '0;
        if (op == OP_PRIME) begin
            for (k = 0; k < WINDOW; k++) begin
                ring_q[k] = smp;
            end
            ring_sum  = 16'(32'(smp) * WINDOW);
            ring_slot = '0;
            return 1'b0;
        end
        if (ring_slot >= WINDOW) begin
            ring_slot = '0;
        end
        ring_sum          = ring_sum - 16'(ring_q[ring_slot]) + 16'(smp);
        ring_q[ring_slot] = smp;
        ring_slot         = ring_slot + 4'd1;
        if (ring_slot >= WINDOW) begin
            ring_slot = '0;
        end
        num = 64'(ring_sum) * 64'(max_rpm_q) * 64'd256;
        rpm = RPM_Q8_BITS'(num / (64'(WINDOW) * 64'(SAMPLE_MAX)));
        return 1'b1;
    endfunction

    task automatic drive_sample(input logic op, input logic [SAMPLE_BITS-1:0] smp,
                                input bit known, input logic [RPM_Q8_BITS-1:0] known_rpm);
        int                     gap;
        logic [RPM_Q8_BITS-1:0] rpm;
        if (calm_items > 0) begin
            gap = 0;
            calm_items--;
        end else begin
            gap = pick_gap();
            if ($urandom_range(0, 99) < 2) begin
                calm_items = $urandom_range(30, 80);
            end
        end
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_op     <= op;
        i_sample <= smp;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        if (advance_filter(op, smp, rpm)) begin
            rpm_expect_q.push_back(known ? known_rpm : rpm);
        end
    endtask

    task automatic write_max_rpm(input logic [RPM_BITS-1:0] value);
        i_valid <= 1'b0;
        while (rpm_expect_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        max_rpm_q = value;
    endtask

    task automatic flag_mismatch(input string what, input logic [RPM_Q8_BITS-1:0] want,
                                 input logic [RPM_Q8_BITS-1:0] got);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("mismatch: %s, expected %0d, actual %0d", what, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (rpm_expect_q.size() == 0) begin
                flag_mismatch("speed with no transaction pending", '0, o_rpm_q8);
            end else if (o_rpm_q8 !== rpm_expect_q[0]) begin
                flag_mismatch("rpm_q8", rpm_expect_q[0], o_rpm_q8);
                void'(rpm_expect_q.pop_front());
            end else begin
                void'(rpm_expect_q.pop_front());
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    initial begin : stall_gen
        int run;
        @(posedge i_clk);
        forever begin
            run = pick_gap();
            if (run > 0) begin
                i_stall <= 1'b1;
                repeat (run) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            if ($urandom_range(0, 99) < 5) begin
                run = $urandom_range(50, 150);
            end else begin
                run = $urandom_range(1, 8);
            end
            repeat (run) @(posedge i_clk);
        end
    end

    initial begin : stimulus
        int                     row;
        int                     phase;
        int                     n;
        logic                   op;
        logic [SAMPLE_BITS-1:0] smp;
        logic [RPM_BITS-1:0]    setting;
        for (row = 0; row < WINDOW; row++) begin
            ring_q[row] = '0;
        end
        ring_sum  = '0;
        ring_slot = '0;
        max_rpm_q = MAX_RPM_RESET;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (row = 0; row < NUM_ROWS; row++) begin
            if (directed_rows[row].kind == ROW_CFG) begin
                write_max_rpm(directed_rows[row].cfg);
            end else begin
                drive_sample(directed_rows[row].op, directed_rows[row].smp,
                             directed_rows[row].kind == ROW_ITEM_KNOWN,
                             directed_rows[row].rpm);
            end
        end

        for (phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: setting = 15'd1;
                1: setting = 15'd20000;
                2: setting = 15'd32767;
                3: setting = 15'd0;
                4: setting = RPM_BITS'($urandom_range(1, 20000));
                5: setting = RPM_BITS'($urandom_range(0, 32767));
                6: setting = MAX_RPM_RESET;
                default: setting = RPM_BITS'($urandom_range(1, 20000));
            endcase
            write_max_rpm(setting);
            for (n = 0; n < PHASE_ITEMS; n++) begin
                op = ($urandom_range(0, 99) < 8) ? OP_PRIME : OP_UPDATE;
                case ($urandom_range(0, 9))
                    0: smp = '0;
                    1: smp = SAMPLE_BITS'(SAMPLE_MAX);
                    default: smp = SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX));
                endcase
                drive_sample(op, smp, 1'b0, '0);
            end
        end

        i_valid <= 1'b0;
        while (rpm_expect_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
